[hdl/lkvc_pkg.sv]
`timescale 1ns / 1ps

package lkvc_pkg;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_TOUCH,
    ST_FINISH
  } lkvc_state_t;

  // request modes
  localparam logic MODE_GET = 1'b0;
  localparam logic MODE_PUT = 1'b1;

  // configuration register map
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned CAP_W      = 5;
  localparam logic [CFG_ADDR_W-1:0] ADDR_CAPACITY = 3'h0;
  localparam logic [CAP_W-1:0]      CAP_RESET     = 5'd16;

endpackage

[hdl/lkvc_req_if.sv]
`timescale 1ns / 1ps

interface lkvc_req_if #(
  parameter int KEY_BITS   = 32,
  parameter int VALUE_BITS = 32
) ();
  logic                  valid;
  logic                  ready;
  logic                  mode;
  logic [KEY_BITS-1:0]   key;
  logic [VALUE_BITS-1:0] value;

  modport source (output valid, mode, key, value, input ready);
  modport sink   (input valid, mode, key, value, output ready);
endinterface

[hdl/lkvc_rsp_if.sv]
`timescale 1ns / 1ps

interface lkvc_rsp_if #(
  parameter int KEY_BITS   = 32,
  parameter int VALUE_BITS = 32
) ();
  logic                  valid;
  logic                  ready;
  logic                  hit;
  logic [VALUE_BITS-1:0] read_value;
  logic                  evicted;
  logic [KEY_BITS-1:0]   evicted_key;

  modport source (output valid, hit, read_value, evicted, evicted_key, input ready);
  modport sink   (input valid, hit, read_value, evicted, evicted_key, output ready);
endinterface

[hdl/lkvc_ram.sv]
`timescale 1ns / 1ps

module lkvc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[hdl/lru_key_value_cache_unit.sv]
`timescale 1ns / 1ps

// fully associative key/value cache with least-recently-used replacement. a request
// (mode 0 = get, mode 1 = put) is taken on in_ch only while the unit is idle, and
// exactly one response follows on out_ch: hit, the stored value on a get hit, and
// on a put miss at capacity the key of the evicted entry. keys, values and ages sit
// in three single-port-write rams that one compare unit walks one slot per cycle.
// a request passes through an idle/accept step, a scan (one ram read per slot,
// registered read data), a decide step, an age update pass (read-modify-write of
// the age ram) and a load of the response register; a get miss skips the age pass.
// the response register lets the next request be accepted while a response still
// waits. capacity (apb offset 0, reset 16) sets how many entries fill before
// eviction starts; zero acts as one, values above ENTRIES saturate. lowering it
// never drops entries, a put miss just evicts one at a time. no clearing pass is
// needed after reset: valid bits live in flops.
module lru_key_value_cache_unit #(
  parameter int ENTRIES    = 16,
  parameter int KEY_BITS   = 32,
  parameter int VALUE_BITS = 32
) (
  input  logic                               clk,
  input  logic                               rst_n,
  lkvc_req_if.sink                           in_ch,
  lkvc_rsp_if.source                         out_ch,
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [lkvc_pkg::CFG_ADDR_W-1:0]    cfg_paddr,
  input  logic [lkvc_pkg::CFG_DATA_W-1:0]    cfg_pwdata,
  output logic [lkvc_pkg::CFG_DATA_W-1:0]    cfg_prdata,
  output logic                               cfg_pready
);

  import lkvc_pkg::*;

  localparam int IDX_W = $clog2(ENTRIES);
  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam int AGE_W = IDX_W;
  localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  // control state
  lkvc_state_t        state_r, state_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               chk_en_r, chk_en_nxt;
  logic [IDX_W-1:0]   chk_idx_r, chk_idx_nxt;
  logic [ENTRIES-1:0] valid_r, valid_nxt;
  logic [CNT_W-1:0]   used_r, used_nxt;
  logic [CAP_W-1:0]   cap_r, cap_nxt;
  logic               out_valid_r, out_valid_nxt;

  // latched request
  logic                  req_mode_r, req_mode_nxt;
  logic [KEY_BITS-1:0]   req_key_r, req_key_nxt;
  logic [VALUE_BITS-1:0] req_value_r, req_value_nxt;

  // scan results
  logic                  found_r, found_nxt;
  logic [IDX_W-1:0]      match_idx_r, match_idx_nxt;
  logic [AGE_W-1:0]      match_age_r, match_age_nxt;
  logic [VALUE_BITS-1:0] match_val_r, match_val_nxt;
  logic                  vic_found_r, vic_found_nxt;
  logic [IDX_W-1:0]      vic_idx_r, vic_idx_nxt;
  logic [AGE_W-1:0]      vic_age_r, vic_age_nxt;
  logic [KEY_BITS-1:0]   vic_key_r, vic_key_nxt;
  logic                  free_found_r, free_found_nxt;
  logic [IDX_W-1:0]      free_idx_r, free_idx_nxt;

  // age update pass
  logic [IDX_W-1:0] slot_r, slot_nxt;
  logic [AGE_W-1:0] old_age_r, old_age_nxt;
  logic             touch_all_r, touch_all_nxt;
  logic             ev_r, ev_nxt;

  // response register
  logic                  out_hit_r, out_hit_nxt;
  logic [VALUE_BITS-1:0] out_rv_r, out_rv_nxt;
  logic                  out_ev_r, out_ev_nxt;
  logic [KEY_BITS-1:0]   out_ek_r, out_ek_nxt;

  // ram ports
  logic [IDX_W-1:0]      rd_addr;
  logic [KEY_BITS-1:0]   key_q;
  logic [VALUE_BITS-1:0] val_q;
  logic [AGE_W-1:0]      age_q;
  logic                  kv_key_we, kv_val_we, age_we;
  logic [IDX_W-1:0]      kv_waddr;
  logic [AGE_W-1:0]      age_wdata;

  logic             in_accept;
  logic             cfg_write;
  logic             scan_issue;
  logic             scan_last;
  logic             slot_v;
  logic [CAP_W-1:0] eff_cap;
  logic             full;

  assign in_accept  = in_ch.valid && in_ch.ready;
  assign cfg_write  = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                      ({cfg_paddr[CFG_ADDR_W-1:2], 2'b00} == ADDR_CAPACITY);
  assign scan_issue = (cnt_r < CNT_W'(ENTRIES));
  assign scan_last  = (cnt_r == CNT_W'(ENTRIES));
  assign rd_addr    = cnt_r[IDX_W-1:0];
  assign slot_v     = valid_r[chk_idx_r];

  // capacity zero behaves as one, anything above ENTRIES saturates
  assign eff_cap = (cap_r == '0) ? CAP_W'(1) : cap_r;
  assign full    = (used_r >= CNT_W'(ENTRIES)) || (CMP_W'(used_r) >= CMP_W'(eff_cap));

  assign cfg_pready = 1'b1;
  assign cfg_prdata = ({cfg_paddr[CFG_ADDR_W-1:2], 2'b00} == ADDR_CAPACITY) ?
                      CFG_DATA_W'(cap_r) : '0;

  assign in_ch.ready        = (state_r == ST_IDLE);
  assign out_ch.valid       = out_valid_r;
  assign out_ch.hit         = out_hit_r;
  assign out_ch.read_value  = out_rv_r;
  assign out_ch.evicted     = out_ev_r;
  assign out_ch.evicted_key = out_ek_r;

  lkvc_ram #(.WIDTH(KEY_BITS), .DEPTH(ENTRIES)) u_key_ram (
    .clk   (clk),
    .we    (kv_key_we),
    .waddr (kv_waddr),
    .wdata (req_key_r),
    .raddr (rd_addr),
    .rdata (key_q)
  );

  lkvc_ram #(.WIDTH(VALUE_BITS), .DEPTH(ENTRIES)) u_val_ram (
    .clk   (clk),
    .we    (kv_val_we),
    .waddr (kv_waddr),
    .wdata (req_value_r),
    .raddr (rd_addr),
    .rdata (val_q)
  );

  lkvc_ram #(.WIDTH(AGE_W), .DEPTH(ENTRIES)) u_age_ram (
    .clk   (clk),
    .we    (age_we),
    .waddr (chk_idx_r),
    .wdata (age_wdata),
    .raddr (rd_addr),
    .rdata (age_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      chk_en_r    <= 1'b0;
      valid_r     <= '0;
      used_r      <= '0;
      cap_r       <= CAP_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      chk_en_r    <= chk_en_nxt;
      valid_r     <= valid_nxt;
      used_r      <= used_nxt;
      cap_r       <= cap_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    chk_idx_r    <= chk_idx_nxt;
    req_mode_r   <= req_mode_nxt;
    req_key_r    <= req_key_nxt;
    req_value_r  <= req_value_nxt;
    found_r      <= found_nxt;
    match_idx_r  <= match_idx_nxt;
    match_age_r  <= match_age_nxt;
    match_val_r  <= match_val_nxt;
    vic_found_r  <= vic_found_nxt;
    vic_idx_r    <= vic_idx_nxt;
    vic_age_r    <= vic_age_nxt;
    vic_key_r    <= vic_key_nxt;
    free_found_r <= free_found_nxt;
    free_idx_r   <= free_idx_nxt;
    slot_r       <= slot_nxt;
    old_age_r    <= old_age_nxt;
    touch_all_r  <= touch_all_nxt;
    ev_r         <= ev_nxt;
    out_hit_r    <= out_hit_nxt;
    out_rv_r     <= out_rv_nxt;
    out_ev_r     <= out_ev_nxt;
    out_ek_r     <= out_ek_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    chk_en_nxt     = 1'b0;
    chk_idx_nxt    = rd_addr;
    valid_nxt      = valid_r;
    used_nxt       = used_r;
    cap_nxt        = cap_r;
    out_valid_nxt  = out_valid_r;
    req_mode_nxt   = req_mode_r;
    req_key_nxt    = req_key_r;
    req_value_nxt  = req_value_r;
    found_nxt      = found_r;
    match_idx_nxt  = match_idx_r;
    match_age_nxt  = match_age_r;
    match_val_nxt  = match_val_r;
    vic_found_nxt  = vic_found_r;
    vic_idx_nxt    = vic_idx_r;
    vic_age_nxt    = vic_age_r;
    vic_key_nxt    = vic_key_r;
    free_found_nxt = free_found_r;
    free_idx_nxt   = free_idx_r;
    slot_nxt       = slot_r;
    old_age_nxt    = old_age_r;
    touch_all_nxt  = touch_all_r;
    ev_nxt         = ev_r;
    out_hit_nxt    = out_hit_r;
    out_rv_nxt     = out_rv_r;
    out_ev_nxt     = out_ev_r;
    out_ek_nxt     = out_ek_r;
    kv_key_we      = 1'b0;
    kv_val_we      = 1'b0;
    kv_waddr       = slot_r;
    age_we         = 1'b0;
    age_wdata      = '0;

    if (cfg_write) begin
      cap_nxt = cfg_pwdata[CAP_W-1:0];
    end

    // response taken downstream
    if (out_ch.valid && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          req_mode_nxt   = in_ch.mode;
          req_key_nxt    = in_ch.key;
          req_value_nxt  = in_ch.value;
          found_nxt      = 1'b0;
          vic_found_nxt  = 1'b0;
          free_found_nxt = 1'b0;
          ev_nxt         = 1'b0;
          cnt_nxt        = '0;
          state_nxt      = ST_SCAN;
        end
      end

      ST_SCAN: begin
        // issue slot cnt_r, examine the slot read in the previous cycle
        if (scan_issue) begin
          chk_en_nxt = 1'b1;
          cnt_nxt    = cnt_r + CNT_W'(1);
        end
        if (chk_en_r) begin
          if (slot_v && (key_q == req_key_r) && !found_r) begin
            found_nxt     = 1'b1;
            match_idx_nxt = chk_idx_r;
            match_age_nxt = age_q;
            match_val_nxt = val_q;
          end
          // oldest valid slot, lowest index on a tie
          if (slot_v && (!vic_found_r || (age_q > vic_age_r))) begin
            vic_found_nxt = 1'b1;
            vic_idx_nxt   = chk_idx_r;
            vic_age_nxt   = age_q;
            vic_key_nxt   = key_q;
          end
          if (!slot_v && !free_found_r) begin
            free_found_nxt = 1'b1;
            free_idx_nxt   = chk_idx_r;
          end
        end
        if (scan_last) begin
          state_nxt = ST_DECIDE;
        end
      end

      ST_DECIDE: begin
        cnt_nxt       = '0;
        touch_all_nxt = 1'b0;
        state_nxt     = ST_FINISH;
        if (found_r) begin
          // hit: refresh recency, put overwrites the value
          slot_nxt    = match_idx_r;
          old_age_nxt = match_age_r;
          kv_waddr    = match_idx_r;
          kv_val_we   = (req_mode_r == MODE_PUT);
          state_nxt   = ST_TOUCH;
        end else if (req_mode_r == MODE_PUT) begin
          if (full && vic_found_r) begin
            // replace the least recent entry
            ev_nxt      = 1'b1;
            slot_nxt    = vic_idx_r;
            old_age_nxt = vic_age_r;
            kv_waddr    = vic_idx_r;
            kv_key_we   = 1'b1;
            kv_val_we   = 1'b1;
            state_nxt   = ST_TOUCH;
          end else if (free_found_r) begin
            // fill the lowest free slot, every live entry ages
            slot_nxt              = free_idx_r;
            touch_all_nxt         = 1'b1;
            kv_waddr              = free_idx_r;
            kv_key_we             = 1'b1;
            kv_val_we             = 1'b1;
            valid_nxt[free_idx_r] = 1'b1;
            used_nxt              = used_r + CNT_W'(1);
            state_nxt             = ST_TOUCH;
          end
        end
      end

      ST_TOUCH: begin
        if (scan_issue) begin
          chk_en_nxt = 1'b1;
          cnt_nxt    = cnt_r + CNT_W'(1);
        end
        if (chk_en_r) begin
          if (chk_idx_r == slot_r) begin
            age_we    = 1'b1;
            age_wdata = '0;
          end else if (slot_v && (touch_all_r || (age_q < old_age_r))) begin
            age_we    = 1'b1;
            age_wdata = age_q + AGE_W'(1);
          end
        end
        if (scan_last) begin
          state_nxt = ST_FINISH;
        end
      end

      ST_FINISH: begin
        // wait for the response register to free up
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_hit_nxt   = found_r;
          out_rv_nxt    = (found_r && (req_mode_r == MODE_GET)) ? match_val_r : '0;
          out_ev_nxt    = ev_r;
          out_ek_nxt    = ev_r ? vic_key_r : '0;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  // fill count tracks the valid bits
  a_used_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_r) == int'(used_r))
    else $error("used count differs from number of valid slots");

  a_used_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    int'(used_r) <= ENTRIES)
    else $error("used count above entry count");

  // one request at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> !in_ch.ready)
    else $error("request accepted while previous still in flight");

  // eviction only happens on a put miss
  a_evict_is_miss: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.evicted) |-> (!out_ch.hit && (out_ch.read_value == '0)))
    else $error("eviction reported together with a hit or read data");
`endif

endmodule
